/* rtl/core/wrrs_pkg.sv */
`timescale 1ns / 1ps

package wrrs_pkg;

	// Field widths of the item and configuration port.
	localparam int COMMAND_W     = 3;
	localparam int CPU_ID_W      = 3;
	localparam int LEVEL_REQ_W   = 8;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int ALLOW_W       = 8;
	localparam int WEIGHT_REG_W  = 64;
	localparam int NUM_WEIGHT_REGS = 4;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_SELECT    = 3'd0,
		CMD_ONLINE    = 3'd1,
		CMD_DOWN      = 3'd2,
		CMD_TRIGGER   = 3'd3,
		CMD_SET_LEVEL = 3'd4
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BALANCE_ENABLE = 3'd0,
		CFG_CPU_ALLOW_MASK = 3'd1,
		CFG_WEIGHTS_LEVEL0 = 3'd2,
		CFG_WEIGHTS_LEVEL1 = 3'd3,
		CFG_WEIGHTS_LEVEL2 = 3'd4,
		CFG_WEIGHTS_LEVEL3 = 3'd5
	} cfg_reg_t;

endpackage

/* rtl/core/wrrs_next_pick.sv */
`timescale 1ns / 1ps

module wrrs_next_pick #(
	parameter int NUM_CPUS = 8
) (
	input  logic [NUM_CPUS-1:0]         mask,
	input  logic [$clog2(NUM_CPUS)-1:0] current,
	input  logic                        wrap_en,
	output logic [$clog2(NUM_CPUS)-1:0] pick
);
	localparam int CPU_W = $clog2(NUM_CPUS);

	logic [NUM_CPUS-1:0] above;
	logic [CPU_W-1:0]    pick_above;
	logic [CPU_W-1:0]    pick_low;

	always_comb begin
		for (int c = 0; c < NUM_CPUS; c++) begin
			above[c] = wrap_en && mask[c] && (CPU_W'(c) > current);
		end
	end

	// Priority encoders: lowest set bit wins, zero when nothing is set.
	always_comb begin
		pick_above = '0;
		pick_low   = '0;
		for (int c = NUM_CPUS - 1; c >= 0; c--) begin
			if (above[c]) begin
				pick_above = CPU_W'(c);
			end
			if (mask[c]) begin
				pick_low = CPU_W'(c);
			end
		end
	end

	assign pick = (above != '0) ? pick_above : pick_low;

endmodule

/* rtl/core/weighted_cpu_round_robin_selector_core.sv */
`timescale 1ns / 1ps

// Weighted round-robin target CPU selector. Each command item is taken into an
// input register and processed, once the result register is free or being
// taken, by one pass of mask logic and a next-candidate priority search, which
// updates the selector state and loads the result register; the result is on
// the outputs from the result register, and one item is accepted every cycle as
// long as the result side keeps taking results. The throughput is set by the
// state update, which one item must finish before the next one reads the state.
// Weight register writes take effect on the next set level, online or trigger
// change command; the user must write configuration only while no item is in
// flight, and the block itself does not enforce this.
module weighted_cpu_round_robin_selector_core #(
	parameter int NUM_CPUS    = 8,
	parameter int NUM_LEVELS  = 4,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wrrs_pkg::COMMAND_W-1:0]     command,
	input  logic [wrrs_pkg::CPU_ID_W-1:0]      cpu_id,
	input  logic [wrrs_pkg::LEVEL_REQ_W-1:0]   level_request,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wrrs_pkg::CPU_ID_W-1:0]      selected_cpu,
	output logic                               status,

	input  logic                               cfg_write,
	input  logic [wrrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wrrs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wrrs_pkg::*;

	localparam int CPU_W = $clog2(NUM_CPUS);
	localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int LVL_N = 1 << LVL_W;

	// Configuration registers.
	logic                    balance_enable_q;
	logic [ALLOW_W-1:0]      allow_q;
	logic [WEIGHT_REG_W-1:0] weight_q [NUM_WEIGHT_REGS];

	// Input stage.
	logic                   valid_s1;
	logic [COMMAND_W-1:0]   cmd_s1;
	logic [CPU_ID_W-1:0]    cpu_s1;
	logic [LEVEL_REQ_W-1:0] req_s1;

	// Result register.
	logic                   out_valid_q;
	logic [CPU_ID_W-1:0]    selected_q;
	logic                   status_q;

	// Selector state.
	logic [NUM_CPUS-1:0]    avail_q, avail_d;
	logic [NUM_CPUS-1:0]    elig_q, elig_d;
	logic [NUM_CPUS-1:0]    cand_q, cand_d;
	logic [WEIGHT_BITS-1:0] base_q [NUM_CPUS];
	logic [WEIGHT_BITS-1:0] base_d [NUM_CPUS];
	logic [WEIGHT_BITS-1:0] credit_q [NUM_CPUS];
	logic [WEIGHT_BITS-1:0] credit_d [NUM_CPUS];
	logic [CPU_W-1:0]       current_q, current_d;
	logic [CPU_W-1:0]       trigger_q, trigger_d;
	logic [LVL_W-1:0]       level_q, level_d;
	logic                   status_d;

	logic                   advance;

	logic [WEIGHT_BITS-1:0] level_w [LVL_N][NUM_CPUS];
	logic [NUM_CPUS-1:0]    allow_vec;
	logic [NUM_CPUS-1:0]    may_balance;
	logic [LVL_W-1:0]       req_level;

	logic                   refill;
	logic [NUM_CPUS-1:0]    sel_mask;
	logic [CPU_W-1:0]       pick;
	logic [WEIGHT_BITS-1:0] credit_pick;
	logic [WEIGHT_BITS-1:0] credit_next;

	logic                   cpu_ok;
	logic [CPU_W-1:0]       cpu_idx;
	logic [NUM_CPUS-1:0]    cpu_bit;
	logic [NUM_CPUS-1:0]    trig_bit;

	// Per-level weight fields; fields past the register and levels without a
	// register read as zero.
	for (genvar l = 0; l < LVL_N; l++) begin : g_level
		for (genvar c = 0; c < NUM_CPUS; c++) begin : g_cpu
			if (l < NUM_LEVELS && l < NUM_WEIGHT_REGS && c * WEIGHT_BITS < WEIGHT_REG_W)
			begin : g_field
				assign level_w[l][c] = WEIGHT_BITS'(weight_q[l] >> (c * WEIGHT_BITS));
			end else begin : g_zero
				assign level_w[l][c] = '0;
			end
		end
	end

	for (genvar c = 0; c < NUM_CPUS; c++) begin : g_allow
		if (c < ALLOW_W) begin : g_bit
			assign allow_vec[c] = allow_q[c];
		end else begin : g_none
			assign allow_vec[c] = 1'b0;
		end
		assign may_balance[c] = allow_vec[c] && (level_w[level_q][c] != '0);
	end

	assign req_level = (32'(req_s1) < NUM_LEVELS) ? req_s1[LVL_W-1:0] : '0;

	assign cpu_ok   = (32'(cpu_s1) < NUM_CPUS);
	assign cpu_idx  = CPU_W'(cpu_s1);
	assign cpu_bit  = NUM_CPUS'(1) << cpu_idx;
	assign trig_bit = NUM_CPUS'(1) << trigger_q;

	// An empty candidate set means the select refills from the eligible mask.
	assign refill   = (cand_q == '0);
	assign sel_mask = refill ? elig_q : cand_q;

	wrrs_next_pick #(
		.NUM_CPUS (NUM_CPUS)
	) u_next_pick (
		.mask    (sel_mask),
		.current (current_q),
		.wrap_en (!refill),
		.pick    (pick)
	);

	assign credit_pick = refill ? base_q[pick] : credit_q[pick];
	assign credit_next = (credit_pick != '0) ? credit_pick - WEIGHT_BITS'(1) : '0;

	always_comb begin
		avail_d   = avail_q;
		elig_d    = elig_q;
		cand_d    = cand_q;
		base_d    = base_q;
		credit_d  = credit_q;
		current_d = current_q;
		trigger_d = trigger_q;
		level_d   = level_q;
		status_d  = 1'b0;
		case (cmd_s1)
			CMD_SELECT: begin
				if (refill) begin
					credit_d = base_q;
				end
				credit_d[pick] = credit_next;
				current_d      = pick;
				cand_d         = sel_mask;
				if (credit_next == '0) begin
					cand_d[pick] = 1'b0;
				end
			end
			CMD_ONLINE: begin
				if (cpu_ok) begin
					avail_d = avail_q | cpu_bit;
					if (may_balance[cpu_idx]) begin
						elig_d = elig_q | cpu_bit;
					end
				end
			end
			CMD_DOWN: begin
				if (cpu_ok) begin
					avail_d = avail_q & ~cpu_bit;
					elig_d  = elig_q & ~cpu_bit;
				end
			end
			CMD_TRIGGER: begin
				if (cpu_ok) begin
					// The previous trigger CPU rejoins before the new one leaves.
					avail_d = avail_q | trig_bit;
					if (may_balance[trigger_q]) begin
						elig_d = elig_q | trig_bit;
						cand_d = cand_q | trig_bit;
					end
					avail_d   = avail_d & ~cpu_bit;
					elig_d    = elig_d & ~cpu_bit;
					cand_d    = cand_d & ~cpu_bit;
					trigger_d = cpu_idx;
				end
			end
			CMD_SET_LEVEL: begin
				if (!balance_enable_q) begin
					status_d = 1'b1;
				end else begin
					level_d = req_level;
					for (int c = 0; c < NUM_CPUS; c++) begin
						base_d[c]   = level_w[req_level][c];
						credit_d[c] = level_w[req_level][c];
						elig_d[c]   = (level_w[req_level][c] != '0) && allow_vec[c] &&
							avail_q[c];
					end
					cand_d = elig_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_enable_q <= 1'b0;
			allow_q          <= '0;
			for (int r = 0; r < NUM_WEIGHT_REGS; r++) begin
				weight_q[r] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BALANCE_ENABLE: balance_enable_q <= cfg_data[0];
				CFG_CPU_ALLOW_MASK: allow_q          <= cfg_data[ALLOW_W-1:0];
				CFG_WEIGHTS_LEVEL0: weight_q[0]      <= cfg_data;
				CFG_WEIGHTS_LEVEL1: weight_q[1]      <= cfg_data;
				CFG_WEIGHTS_LEVEL2: weight_q[2]      <= cfg_data;
				CFG_WEIGHTS_LEVEL3: weight_q[3]      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= command;
			cpu_s1 <= cpu_id;
			req_s1 <= level_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			selected_q <= CPU_ID_W'(current_d);
			status_q   <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q   <= '1;
			elig_q    <= '0;
			cand_q    <= '0;
			current_q <= '0;
			trigger_q <= '0;
			level_q   <= '0;
			for (int c = 0; c < NUM_CPUS; c++) begin
				base_q[c]   <= '0;
				credit_q[c] <= '0;
			end
		end else if (advance) begin
			avail_q   <= avail_d;
			elig_q    <= elig_d;
			cand_q    <= cand_d;
			current_q <= current_d;
			trigger_q <= trigger_d;
			level_q   <= level_d;
			base_q    <= base_d;
			credit_q  <= credit_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign selected_cpu = selected_q;
	assign status       = status_q;

endmodule

/* verif/wrrs_selection_checker.sv */
`timescale 1ns / 1ps

module wrrs_selection_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [wrrs_pkg::COMMAND_W-1:0]   command,
	input  logic [wrrs_pkg::CPU_ID_W-1:0]    cpu_id,
	input  logic [wrrs_pkg::LEVEL_REQ_W-1:0] level_request,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [wrrs_pkg::CPU_ID_W-1:0]    selected_cpu,
	input  logic                             status,
	input  logic                             cfg_write,
	input  logic [wrrs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wrrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               fail_count,
	output int                               pending,
	output int                               result_count,
	output int                               refill_count,
	output int                               reject_count
);
	import wrrs_pkg::*;

	localparam int NCPU  = 8;
	localparam int NLEV  = 4;
	localparam int WBITS = 8;

	typedef struct packed {
		logic [CPU_ID_W-1:0] cpu;
		logic                status;
	} sel_result_t;

	// Register copies.
	logic                    bal_en;
	logic [ALLOW_W-1:0]      allow;
	logic [WEIGHT_REG_W-1:0] wreg [NUM_WEIGHT_REGS];

	// Selector state.
	logic [NCPU-1:0]     online_m;
	logic [NCPU-1:0]     elig_m;
	logic [NCPU-1:0]     cand_m;
	logic [WBITS-1:0]    base_w [NCPU];
	logic [WBITS-1:0]    credit [NCPU];
	logic [CPU_ID_W-1:0] cur;
	logic [CPU_ID_W-1:0] trig;
	logic [1:0]          lvl;

	sel_result_t expected_picks[$];

	function automatic logic [WBITS-1:0] weight_of(input logic [1:0] l, input int c);
		return wreg[l][c*WBITS +: WBITS];
	endfunction

	function automatic int next_set(input logic [NCPU-1:0] m, input int from);
		for (int c = from; c < NCPU; c++)
			if (m[c])
				return c;
		return NCPU;
	endfunction

	task automatic advance_pick();
		int pick;
		if (cand_m != '0) begin
			pick = next_set(cand_m, int'(cur) + 1);
			if (pick >= NCPU)
				pick = next_set(cand_m, 0);
		end else begin
			// Round exhausted: refill every credit and restart from the eligible set.
			for (int c = 0; c < NCPU; c++)
				credit[c] = base_w[c];
			cand_m = elig_m;
			pick = next_set(cand_m, 0);
			refill_count++;
		end
		if (pick >= NCPU)
			pick = 0;
		if (credit[pick] != '0)
			credit[pick] = credit[pick] - 1'b1;
		cur = CPU_ID_W'(pick);
		if (credit[pick] == '0)
			cand_m[pick] = 1'b0;
	endtask

	task automatic move_trigger(input logic [CPU_ID_W-1:0] c);
		// The old trigger CPU rejoins the rotation if it may take work.
		online_m[trig] = 1'b1;
		if (allow[trig] && weight_of(lvl, trig) != '0) begin
			elig_m[trig] = 1'b1;
			cand_m[trig] = 1'b1;
		end
		online_m[c] = 1'b0;
		elig_m[c]   = 1'b0;
		cand_m[c]   = 1'b0;
		trig        = c;
	endtask

	task automatic load_level(input logic [LEVEL_REQ_W-1:0] req);
		lvl    = (req >= NLEV) ? 2'd0 : req[1:0];
		elig_m = '0;
		for (int c = 0; c < NCPU; c++) begin
			base_w[c] = weight_of(lvl, c);
			credit[c] = base_w[c];
			if (base_w[c] != '0 && allow[c] && online_m[c])
				elig_m[c] = 1'b1;
		end
		cand_m = elig_m;
	endtask

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		sel_result_t want;
		sel_result_t got;
		sel_result_t next_result;
		logic        rejected;
		if (!arst_n) begin
			bal_en   = 1'b0;
			allow    = '0;
			for (int r = 0; r < NUM_WEIGHT_REGS; r++)
				wreg[r] = '0;
			online_m = '1;
			elig_m   = '0;
			cand_m   = '0;
			for (int c = 0; c < NCPU; c++) begin
				base_w[c] = '0;
				credit[c] = '0;
			end
			cur          = '0;
			trig         = '0;
			lvl          = '0;
			fail_count   = 0;
			result_count = 0;
			refill_count = 0;
			reject_count = 0;
			expected_picks.delete();
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_BALANCE_ENABLE: bal_en = cfg_data[0];
					CFG_CPU_ALLOW_MASK: allow = cfg_data[ALLOW_W-1:0];
					CFG_WEIGHTS_LEVEL0, CFG_WEIGHTS_LEVEL1,
					CFG_WEIGHTS_LEVEL2, CFG_WEIGHTS_LEVEL3: begin
						wreg[cfg_index - CFG_WEIGHTS_LEVEL0] = cfg_data;
					end
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				got.cpu    = selected_cpu;
				got.status = status;
				result_count++;
				if (expected_picks.size() == 0) begin
					flag($sformatf("result cpu %0d status %0d with nothing expected",
						got.cpu, got.status));
				end else begin
					want = expected_picks.pop_front();
					if (got.cpu !== want.cpu || got.status !== want.status)
						flag($sformatf("expected cpu %0d status %0d, got cpu %0d status %0d",
							want.cpu, want.status, got.cpu, got.status));
				end
			end

			if (in_valid && in_ready) begin
				rejected = 1'b0;
				case (command)
					CMD_SELECT: advance_pick();
					CMD_ONLINE: begin
						online_m[cpu_id] = 1'b1;
						if (allow[cpu_id] && weight_of(lvl, cpu_id) != '0)
							elig_m[cpu_id] = 1'b1;
					end
					CMD_DOWN: begin
						online_m[cpu_id] = 1'b0;
						elig_m[cpu_id]   = 1'b0;
					end
					CMD_TRIGGER: move_trigger(cpu_id);
					CMD_SET_LEVEL: begin
						if (!bal_en) begin
							rejected = 1'b1;
							reject_count++;
						end else begin
							load_level(level_request);
						end
					end
					default: ;
				endcase
				next_result.cpu    = cur;
				next_result.status = rejected;
				expected_picks.push_back(next_result);
			end
			pending <= expected_picks.size();
		end
	end

endmodule

/* verif/tb_weighted_cpu_round_robin_selector_core.sv */
`timescale 1ns / 1ps

module tb_weighted_cpu_round_robin_selector_core;
	import wrrs_pkg::*;

	localparam int NCPU         = 8;
	localparam int LEVELS       = 4;
	localparam int CMD_CODES    = 1 << COMMAND_W;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 150;
	localparam int IDLE_LIMIT   = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [COMMAND_W-1:0]   command = '0;
	logic [CPU_ID_W-1:0]    cpu_id = '0;
	logic [LEVEL_REQ_W-1:0] level_request = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CPU_ID_W-1:0]    selected_cpu;
	logic                   status;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left;
	int idle_cycles = 0;
	int items_sent = 0;
	int fail_count;
	int pending;
	int result_count;
	int refill_count;
	int reject_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	weighted_cpu_round_robin_selector_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.cpu_id        (cpu_id),
		.level_request (level_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.selected_cpu  (selected_cpu),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	wrrs_selection_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.cpu_id        (cpu_id),
		.level_request (level_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.selected_cpu  (selected_cpu),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.result_count  (result_count),
		.refill_count  (refill_count),
		.reject_count  (reject_count)
	);

	// Result side stalls in bursts of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic [COMMAND_W-1:0] cmd, input logic [CPU_ID_W-1:0] cpu,
			input logic [LEVEL_REQ_W-1:0] req);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		cpu_id        <= cpu;
		level_request <= req;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drop valid in the step of the last acceptance, then wait for all results.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic en, input logic [ALLOW_W-1:0] allow_mask,
			input logic [63:0] w0, input logic [63:0] w1, input logic [63:0] w2,
			input logic [63:0] w3);
		write_reg(CFG_BALANCE_ENABLE, CFG_DATA_W'(en));
		write_reg(CFG_CPU_ALLOW_MASK, CFG_DATA_W'(allow_mask));
		write_reg(CFG_WEIGHTS_LEVEL0, w0);
		write_reg(CFG_WEIGHTS_LEVEL1, w1);
		write_reg(CFG_WEIGHTS_LEVEL2, w2);
		write_reg(CFG_WEIGHTS_LEVEL3, w3);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small weights so that credits run out and refill often.
	function automatic logic [63:0] rand_weights();
		logic [63:0] w;
		for (int c = 0; c < NCPU; c++) begin
			case ($urandom_range(0, 11))
				0, 1, 2: w[c*8 +: 8] = 8'h00;
				10: w[c*8 +: 8] = 8'hFF;
				11: w[c*8 +: 8] = 8'($urandom_range(0, 255));
				default: w[c*8 +: 8] = 8'($urandom_range(1, 3));
			endcase
		end
		return w;
	endfunction

	task automatic send_random();
		logic [COMMAND_W-1:0]   cmd;
		logic [LEVEL_REQ_W-1:0] req;
		int                     r;
		r = $urandom_range(0, 99);
		if (r < 50)
			cmd = CMD_SELECT;
		else if (r < 60)
			cmd = CMD_ONLINE;
		else if (r < 70)
			cmd = CMD_DOWN;
		else if (r < 82)
			cmd = CMD_TRIGGER;
		else if (r < 94)
			cmd = CMD_SET_LEVEL;
		else
			cmd = COMMAND_W'($urandom_range(int'(CMD_SET_LEVEL) + 1, CMD_CODES - 1));
		if ($urandom_range(0, 3) != 0)
			req = LEVEL_REQ_W'($urandom_range(0, LEVELS - 1));
		else
			req = LEVEL_REQ_W'($urandom_range(0, 255));
		send_item(cmd, CPU_ID_W'($urandom_range(0, NCPU - 1)), req);
	endtask

	initial begin
		logic                en;
		logic [ALLOW_W-1:0]  allow_mask;
		logic [63:0]         w [4];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: nothing eligible, level changes are refused.
		gap_pct = 20;
		stall_pct <= 10;
		send_item(CMD_SELECT, 3'd0, 8'd0);
		send_item(CMD_SET_LEVEL, 3'd0, 8'd1);
		for (int k = int'(CMD_SET_LEVEL) + 1; k < CMD_CODES; k++)
			send_item(COMMAND_W'(k), CPU_ID_W'(k), 8'h00);
		settle();

		configure(1'b1, 8'hFF, 64'h0102_0003_0101_0201, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0, 64'h0000_0001_0000_0002);
		send_item(CMD_SET_LEVEL, 3'd0, 8'd0);
		repeat (4) send_item(CMD_SELECT, 3'd0, 8'd0);
		send_item(CMD_DOWN, 3'd7, 8'd0);
		send_item(CMD_ONLINE, 3'd7, 8'd0);
		send_item(CMD_TRIGGER, 3'd0, 8'd0);
		send_item(CMD_TRIGGER, 3'd6, 8'd0);
		repeat (2) send_item(CMD_SELECT, 3'd0, 8'd0);
		// A level whose weights are all zero leaves the selector on CPU 0.
		send_item(CMD_SET_LEVEL, 3'd0, 8'd2);
		send_item(CMD_SELECT, 3'd0, 8'd0);
		send_item(CMD_SET_LEVEL, 3'd0, 8'd9);
		send_item(CMD_SET_LEVEL, 3'd7, 8'hFF);
		send_item(CMD_SET_LEVEL, 3'd0, 8'd3);
		repeat (2) send_item(CMD_SELECT, 3'd0, 8'd0);
		send_item(CMD_SET_LEVEL, 3'd0, 8'd1);
		send_item(CMD_SELECT, 3'd0, 8'd0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			en = (p % 4 != 3);
			if (p == 1)
				allow_mask = 8'h00;
			else if (p == 2)
				allow_mask = 8'hFF;
			else
				allow_mask = ALLOW_W'($urandom_range(0, 255));
			for (int r = 0; r < 4; r++) begin
				if (p == 4)
					w[r] = '1;
				else if (p == 5)
					w[r] = '0;
				else
					w[r] = rand_weights();
			end
			configure(en, allow_mask, w[0], w[1], w[2], w[3]);

			// The last phase runs without any idling on either side.
			if (p == PHASES - 1) begin
				gap_pct = 0;
				stall_pct <= 0;
			end else begin
				gap_pct = (p % 3) * 15;
				stall_pct <= (p % 3) * 12;
			end

			send_item(CMD_SET_LEVEL, CPU_ID_W'($urandom_range(0, NCPU - 1)),
				LEVEL_REQ_W'($urandom_range(0, LEVELS - 1)));
			repeat (PHASE_ITEMS - 1) send_random();
			settle();
		end

		$display("Run covered %0d command items over %0d register settings, directed corners first,",
			items_sent, PHASES + 2);
		$display("then random traffic with idle bursts; %0d results checked, %0d refills, %0d refusals.",
			result_count, refill_count, reject_count);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d results mismatched", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/wrrs_pkg.sv
rtl/core/wrrs_next_pick.sv
rtl/core/weighted_cpu_round_robin_selector_core.sv
verif/wrrs_selection_checker.sv
verif/tb_weighted_cpu_round_robin_selector_core.sv
